FILE: rtl/sscp_pkg.sv
// Shared types and constants for the servo serial command parser.
`default_nettype none
package sscp_pkg;

    // Characters of the protocol
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_G      = 8'h47;

    // Result kinds
    localparam logic [1:0] KIND_AXIS   = 2'd0;
    localparam logic [1:0] KIND_STORED = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    // Item codes
    localparam logic [3:0] ITEM_P       = 4'd0;
    localparam logic [3:0] ITEM_I       = 4'd1;
    localparam logic [3:0] ITEM_D       = 4'd2;
    localparam logic [3:0] ITEM_W       = 4'd3;
    localparam logic [3:0] ITEM_S       = 4'd4;
    localparam logic [3:0] ITEM_F       = 4'd5;
    localparam logic [3:0] ITEM_A       = 4'd6;
    localparam logic [3:0] ITEM_G       = 4'd7;
    localparam logic [3:0] ITEM_POS     = 4'd8;
    localparam logic [3:0] ITEM_STATUS  = 4'd9;
    localparam logic [3:0] ITEM_UNKNOWN = 4'd10;

    localparam int PARAM_COUNT = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0]         rx_byte;
        logic signed [31:0] position;
        logic [7:0]         status_byte;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         item;
        logic signed [31:0] value;
        logic               save_request;
    } rsp_t;

    // Classified byte passed from front to back
    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] position;
        logic [7:0]  status_byte;
        logic        is_dollar;
        logic        is_at;
        logic        is_bang;
        logic        is_equal;
        logic        is_cr;
        logic        is_print;
        logic        is_digit;
        logic        is_space;
        logic        is_minus;
        logic        is_plus;
        logic [3:0]  digit;
        logic [3:0]  letter_idx;
    } cls_t;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_CMD,
        PH_LETTER,
        PH_NUMBER
    } phase_t;

    typedef enum logic [1:0] {
        NP_SPACE,
        NP_DIGITS,
        NP_DONE
    } num_phase_t;

endpackage
`default_nettype wire

FILE: rtl/sscp_front.sv
// Front end: classifies each received byte for the command sequencer.
`default_nettype none
module sscp_front (
    input  wire sscp_pkg::cmd_t cmd,
    output sscp_pkg::cls_t      cls
);

    logic [3:0] letter_idx;

    always_comb
    begin
        case (cmd.rx_byte)
            sscp_pkg::CH_P: letter_idx = sscp_pkg::ITEM_P;
            sscp_pkg::CH_I: letter_idx = sscp_pkg::ITEM_I;
            sscp_pkg::CH_D: letter_idx = sscp_pkg::ITEM_D;
            sscp_pkg::CH_W: letter_idx = sscp_pkg::ITEM_W;
            sscp_pkg::CH_S: letter_idx = sscp_pkg::ITEM_S;
            sscp_pkg::CH_F: letter_idx = sscp_pkg::ITEM_F;
            sscp_pkg::CH_A: letter_idx = sscp_pkg::ITEM_A;
            sscp_pkg::CH_G: letter_idx = sscp_pkg::ITEM_G;
            default:        letter_idx = sscp_pkg::ITEM_UNKNOWN;
        endcase
    end

    always_comb
    begin
        cls.rx_byte     = cmd.rx_byte;
        cls.position    = cmd.position;
        cls.status_byte = cmd.status_byte;
        cls.is_dollar   = (cmd.rx_byte == sscp_pkg::CH_DOLLAR);
        cls.is_at       = (cmd.rx_byte == sscp_pkg::CH_AT);
        cls.is_bang     = (cmd.rx_byte == sscp_pkg::CH_BANG);
        cls.is_equal    = (cmd.rx_byte == sscp_pkg::CH_EQUAL);
        cls.is_cr       = (cmd.rx_byte == sscp_pkg::CH_CR);
        cls.is_print    = (cmd.rx_byte >= sscp_pkg::CH_SPACE) &&
                          (cmd.rx_byte <= sscp_pkg::CH_TILDE);
        cls.is_digit    = (cmd.rx_byte >= sscp_pkg::CH_ZERO) &&
                          (cmd.rx_byte <= sscp_pkg::CH_NINE);
        cls.is_space    = (cmd.rx_byte == sscp_pkg::CH_SPACE);
        cls.is_minus    = (cmd.rx_byte == sscp_pkg::CH_MINUS);
        cls.is_plus     = (cmd.rx_byte == sscp_pkg::CH_PLUS);
        cls.digit       = cmd.rx_byte[3:0];
        cls.letter_idx  = letter_idx;
    end

endmodule
`default_nettype wire

FILE: rtl/sscp_fifo.sv
// Short queue of classified words between front and back.
`default_nettype none
module sscp_fifo (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire sscp_pkg::cls_t push_data,
    output logic                full,
    input  wire                 pop,
    output sscp_pkg::cls_t      pop_data,
    output logic                not_empty
);

    localparam int DEPTH = sscp_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    sscp_pkg::cls_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sscp_back.sv
// Back end: command sequencer, number parser, parameter file and result register.
`default_nettype none
module sscp_back #(
    parameter int BUFFER_LIMIT = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 word_valid,
    input  wire sscp_pkg::cls_t word,
    output logic                word_pop,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output sscp_pkg::rsp_t      rsp_data
);

    localparam int CW = $clog2(BUFFER_LIMIT);
    localparam logic [CW-1:0] CNT_MAX   = CW'(BUFFER_LIMIT - 1);
    localparam logic [CW-1:0] CNT_START = CW'(3);

    sscp_pkg::phase_t     phase_reg, phase_next;
    sscp_pkg::num_phase_t nphase_reg, nphase_next;
    logic                 dollar_reg, dollar_next;
    logic [3:0]           cmd_idx_reg, cmd_idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          acc_reg, acc_next;
    logic [7:0]           axis_reg, axis_next;
    logic [31:0]          param_reg [sscp_pkg::PARAM_COUNT];
    logic [31:0]          param_next [sscp_pkg::PARAM_COUNT];
    logic                 rsp_valid_reg, rsp_valid_next;
    sscp_pkg::rsp_t       rsp_data_reg;

    logic                 res_valid;
    sscp_pkg::rsp_t       res_data;
    logic [31:0]          acc_times_ten;
    logic [31:0]          signed_val;

    assign word_pop      = word_valid && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid     = rsp_valid_reg;
    assign rsp_data      = rsp_data_reg;
    assign acc_times_ten = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};
    assign signed_val    = neg_reg ? (32'd0 - acc_reg) : acc_reg;

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        nphase_next  = nphase_reg;
        dollar_next  = dollar_reg;
        cmd_idx_next = cmd_idx_reg;
        count_next   = count_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        axis_next    = axis_reg;
        param_next   = param_reg;
        if (word_pop)
        begin
            case (phase_reg)
                sscp_pkg::PH_ADDR:
                begin
                    if (word.is_dollar || (word.rx_byte == axis_reg))
                    begin
                        dollar_next = word.is_dollar;
                        phase_next  = sscp_pkg::PH_CMD;
                    end
                end
                sscp_pkg::PH_CMD:
                begin
                    if (dollar_reg)
                    begin
                        axis_next  = word.rx_byte;
                        phase_next = sscp_pkg::PH_ADDR;
                    end
                    else if (word.is_at || word.is_bang)
                    begin
                        phase_next = sscp_pkg::PH_ADDR;
                    end
                    else
                    begin
                        cmd_idx_next = word.letter_idx;
                        phase_next   = sscp_pkg::PH_LETTER;
                    end
                end
                sscp_pkg::PH_LETTER:
                begin
                    if (word.is_equal)
                    begin
                        phase_next  = sscp_pkg::PH_NUMBER;
                        count_next  = CNT_START;
                        nphase_next = sscp_pkg::NP_SPACE;
                        neg_next    = 1'b0;
                        acc_next    = '0;
                    end
                    else
                    begin
                        phase_next = sscp_pkg::PH_ADDR;
                    end
                end
                sscp_pkg::PH_NUMBER:
                begin
                    if (word.is_print && (count_reg < CNT_MAX))
                    begin
                        count_next = count_reg + 1'b1;
                        case (nphase_reg)
                            sscp_pkg::NP_SPACE:
                            begin
                                if (word.is_space)
                                begin
                                    nphase_next = sscp_pkg::NP_SPACE;
                                end
                                else if (word.is_minus)
                                begin
                                    neg_next    = 1'b1;
                                    nphase_next = sscp_pkg::NP_DIGITS;
                                end
                                else if (word.is_plus)
                                begin
                                    nphase_next = sscp_pkg::NP_DIGITS;
                                end
                                else if (word.is_digit)
                                begin
                                    acc_next    = {28'd0, word.digit};
                                    nphase_next = sscp_pkg::NP_DIGITS;
                                end
                                else
                                begin
                                    nphase_next = sscp_pkg::NP_DONE;
                                end
                            end
                            sscp_pkg::NP_DIGITS:
                            begin
                                if (word.is_digit)
                                begin
                                    acc_next = acc_times_ten + {28'd0, word.digit};
                                end
                                else
                                begin
                                    nphase_next = sscp_pkg::NP_DONE;
                                end
                            end
                            default:
                            begin
                                nphase_next = nphase_reg;
                            end
                        endcase
                    end
                    if (word.is_cr)
                    begin
                        if (!cmd_idx_reg[3])
                        begin
                            param_next[cmd_idx_reg[2:0]] = signed_val;
                        end
                        phase_next = sscp_pkg::PH_ADDR;
                    end
                end
                default:
                begin
                    phase_next = sscp_pkg::PH_ADDR;
                end
            endcase
        end
    end

    // result of the current word
    always_comb
    begin
        res_valid             = 1'b0;
        res_data.kind         = sscp_pkg::KIND_AXIS;
        res_data.item         = sscp_pkg::ITEM_P;
        res_data.value        = '0;
        res_data.save_request = 1'b0;
        case (phase_reg)
            sscp_pkg::PH_CMD:
            begin
                if (dollar_reg)
                begin
                    res_valid             = 1'b1;
                    res_data.kind         = sscp_pkg::KIND_AXIS;
                    res_data.value        = {24'd0, word.rx_byte};
                    res_data.save_request = 1'b1;
                end
                else if (word.is_at)
                begin
                    res_valid      = 1'b1;
                    res_data.kind  = sscp_pkg::KIND_REPORT;
                    res_data.item  = sscp_pkg::ITEM_POS;
                    res_data.value = word.position;
                end
                else if (word.is_bang)
                begin
                    res_valid      = 1'b1;
                    res_data.kind  = sscp_pkg::KIND_REPORT;
                    res_data.item  = sscp_pkg::ITEM_STATUS;
                    res_data.value = {24'd0, word.status_byte};
                end
            end
            sscp_pkg::PH_LETTER:
            begin
                if (word.is_at)
                begin
                    res_valid     = 1'b1;
                    res_data.item = cmd_idx_reg;
                    // G and unknown letters have nothing to read back
                    if (cmd_idx_reg < sscp_pkg::ITEM_G)
                    begin
                        res_data.kind  = sscp_pkg::KIND_REPORT;
                        res_data.value = param_reg[cmd_idx_reg[2:0]];
                    end
                    else
                    begin
                        res_data.kind = sscp_pkg::KIND_EMPTY;
                    end
                end
            end
            sscp_pkg::PH_NUMBER:
            begin
                if (word.is_cr)
                begin
                    res_valid             = 1'b1;
                    res_data.kind         = sscp_pkg::KIND_STORED;
                    res_data.item         = cmd_idx_reg;
                    res_data.value        = signed_val;
                    res_data.save_request = 1'b1;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (word_pop)
        begin
            rsp_valid_next = res_valid;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sscp_pkg::PH_ADDR;
            nphase_reg    <= sscp_pkg::NP_SPACE;
            dollar_reg    <= 1'b0;
            cmd_idx_reg   <= sscp_pkg::ITEM_UNKNOWN;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            axis_reg      <= sscp_pkg::CH_ONE;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < sscp_pkg::PARAM_COUNT; i++)
            begin
                param_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            nphase_reg    <= nphase_next;
            dollar_reg    <= dollar_next;
            cmd_idx_reg   <= cmd_idx_next;
            count_reg     <= count_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            axis_reg      <= axis_next;
            rsp_valid_reg <= rsp_valid_next;
            param_reg     <= param_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_pop && res_valid)
        begin
            rsp_data_reg <= res_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/servo_serial_command_parser_core.sv
// Servo serial command parser: byte classifier, word queue and command sequencer.
//
// Usage: received serial bytes enter on the cmd channel (valid/ready), each word
// carrying the byte plus the current servo position and status. Commands are
// "$x" (set axis), "<axis>@" / "<axis>!" (position / status report),
// "<axis>L@" (parameter report) and "<axis>L=number CR" (store parameter).
// Results leave on the rsp channel (valid/ready), at most one per byte.
// Path: a byte is classified combinationally and written into the queue when
// accepted; the sequencer then pops it and registers its result in the result
// register, which drives rsp_valid.
// Throughput: one byte per cycle unless rsp stalls; the sequencer handles one
// word a cycle, with the x10 accumulate (two shifted adds) as its longest path.
// Stall: while a result waits with rsp_ready low, the result register holds and
// the sequencer stops, also for bytes that would give no result. The
// two-entry queue keeps taking bytes until full, then cmd_ready drops.
// Reset: axis is '1', all eight parameters are zero, the parser waits for an
// address byte and both the queue and the result register are empty.
`default_nettype none
module servo_serial_command_parser_core #(
    parameter int BUFFER_LIMIT = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_ready,
    input  wire sscp_pkg::cmd_t cmd_data,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output sscp_pkg::rsp_t      rsp_data
);

    sscp_pkg::cls_t cls;
    sscp_pkg::cls_t q_word;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;

    assign cmd_ready = !q_full;

    sscp_front u_front (
        .cmd (cmd_data),
        .cls (cls)
    );

    sscp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid && cmd_ready),
        .push_data (cls),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_word),
        .not_empty (q_valid)
    );

    sscp_back #(
        .BUFFER_LIMIT (BUFFER_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (q_valid),
        .word       (q_word),
        .word_pop   (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_data   (rsp_data)
    );

endmodule
`default_nettype wire
